[rtl/eos_pkg.sv]
package eos_pkg;

    localparam int FLOORS = 4;
    localparam int FLW    = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int CMP_W  = (FLW > 2) ? FLW : 2;

    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;
    localparam logic [1:0] DIR_DOWN    = 2'd2;
    localparam logic [1:0] DIR_UNKNOWN = 2'd3;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic       load;
        logic       press_valid;
        logic [1:0] press_floor;
        logic [1:0] press_button;
        logic       clear_here;
        logic [1:0] pos;
    } t_cell_ctl;

    // scan token handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic       below;
        logic [2:0] here;
        logic       above;
        logic       any;
    } t_scan;

    typedef struct packed {
        logic       stop_here;
        logic [1:0] next_dir;
        logic       any_order;
        logic [2:0] floor_calls;
    } t_rsp;

endpackage

[rtl/eos_req_if.sv]
interface eos_req_if;
    logic       valid;
    logic       ready;
    logic       press_valid;
    logic [1:0] press_floor;
    logic [1:0] press_button;
    logic       clear_here;
    logic [1:0] position_floor;
    logic       between_floors;
    logic [1:0] travel_dir;

    modport source (
        output valid, press_valid, press_floor, press_button, clear_here,
               position_floor, between_floors, travel_dir,
        input  ready
    );
    modport sink (
        input  valid, press_valid, press_floor, press_button, clear_here,
               position_floor, between_floors, travel_dir,
        output ready
    );
endinterface

[rtl/eos_rsp_if.sv]
interface eos_rsp_if;
    logic       valid;
    logic       ready;
    logic       stop_here;
    logic [1:0] next_dir;
    logic       any_order;
    logic [2:0] floor_calls;

    modport source (
        output valid, stop_here, next_dir, any_order, floor_calls,
        input  ready
    );
    modport sink (
        input  valid, stop_here, next_dir, any_order, floor_calls,
        output ready
    );
endinterface

[rtl/elevator_order_scheduler.sv]
// Pending-call table for an elevator car with an up/down sweep. Each request
// may record one button press and clear the calls at the position floor; the
// response reports stop_here, next_dir, any_order and the position floor's
// call flags from the updated table. One cell per floor holds that floor's
// flags, and a scan token walks the chain one floor per cycle; a response passes
// the start register, the cell registers, a pending register and the output register
// after its request is accepted, and the next request is taken once that response
// enters the output register, so one request is scanned at a time. A finished
// response may wait in the output register while the next request is accepted
// and scanned.
module elevator_order_scheduler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eos_req_if.sink   i_req,
    eos_rsp_if.source o_rsp
);
    import eos_pkg::*;

    t_cell_ctl  w_ctl;
    t_scan      w_scan [FLOORS+1];
    logic       w_accept;
    logic       w_move;
    t_rsp       w_res;
    logic       w_up_side;

    logic       r_busy;
    logic       r_start;
    logic [1:0] r_pos;
    logic       r_btw;
    logic [1:0] r_dir;
    logic       r_pend_v;
    t_rsp       r_pend;
    logic       r_out_v;
    t_rsp       r_out;

    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;
    assign w_move      = r_pend_v && (!r_out_v || o_rsp.ready);

    assign w_ctl.load         = w_accept;
    assign w_ctl.press_valid  = i_req.press_valid;
    assign w_ctl.press_floor  = i_req.press_floor;
    assign w_ctl.press_button = i_req.press_button;
    assign w_ctl.clear_here   = i_req.clear_here;
    assign w_ctl.pos          = w_accept ? i_req.position_floor : r_pos;

    assign w_scan[0] = '{valid: r_start, below: 1'b0, here: 3'b000,
                         above: 1'b0, any: 1'b0};

    for (genvar g = 0; g < FLOORS; g++) begin : g_cell
        eos_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (FLW'(g)),
            .i_ctl   (w_ctl),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1])
        );
    end

    // decide from the finished scan
    always_comb begin
        t_scan s;
        s = w_scan[FLOORS];
        w_up_side            = s.above || (s.here != 3'b000);
        w_res.any_order      = s.any;
        w_res.floor_calls    = s.here;
        w_res.stop_here      = 1'b0;
        w_res.next_dir       = DIR_STOP;
        if (r_btw) begin
            if (w_up_side) begin
                w_res.next_dir = DIR_UP;
            end else if (s.below) begin
                w_res.next_dir = DIR_DOWN;
            end
        end else begin
            if (s.here[2]) begin
                w_res.stop_here = 1'b1;
            end else if (s.here[1] && (r_dir == DIR_DOWN)) begin
                w_res.stop_here = 1'b1;
            end else if (s.here[0] && (r_dir == DIR_UP)) begin
                w_res.stop_here = 1'b1;
            end else if (s.here != 3'b000) begin
                case (r_dir)
                    DIR_UP:   w_res.stop_here = !s.above;
                    DIR_DOWN: w_res.stop_here = !s.below;
                    default:  w_res.stop_here = 1'b1;
                endcase
            end
            if (r_dir == DIR_DOWN) begin
                if (s.below) begin
                    w_res.next_dir = DIR_DOWN;
                end else if (s.above) begin
                    w_res.next_dir = DIR_UP;
                end
            end else begin
                if (s.above) begin
                    w_res.next_dir = DIR_UP;
                end else if (s.below) begin
                    w_res.next_dir = DIR_DOWN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_start  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_start <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_scan[FLOORS].valid) begin
                r_pend_v <= 1'b1;
            end else if (w_move) begin
                r_pend_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (w_accept) begin
            r_pos <= i_req.position_floor;
            r_btw <= i_req.between_floors;
            // treat an unknown direction as stop
            r_dir <= (i_req.travel_dir == DIR_UNKNOWN) ? DIR_STOP : i_req.travel_dir;
        end
        if (w_scan[FLOORS].valid) begin
            r_pend <= w_res;
        end
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.stop_here   = r_out.stop_here;
    assign o_rsp.next_dir    = r_out.next_dir;
    assign o_rsp.any_order   = r_out.any_order;
    assign o_rsp.floor_calls = r_out.floor_calls;

    logic [FLOORS:0] w_tok;
    always_comb begin
        for (int k = 0; k <= FLOORS; k++) begin
            w_tok[k] = w_scan[k].valid;
        end
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one scan token in the chain");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[FLOORS].valid |-> !r_pend_v)
        else $error("scan result overwrites a pending response");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_busy)
        else $error("pending response without a busy request");

    a_stop_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.stop_here) |-> (o_rsp.floor_calls != 3'b000))
        else $error("stop reported with no call at the floor");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok) |-> r_busy)
        else $error("scan running while idle");

endmodule

[rtl/eos_cell.sv]
module eos_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [eos_pkg::FLW-1:0] i_index,
    input  eos_pkg::t_cell_ctl i_ctl,
    input  eos_pkg::t_scan     i_scan,
    output eos_pkg::t_scan     o_scan
);
    import eos_pkg::*;

    logic [2:0]       r_calls;
    logic [2:0]       n_calls;
    t_scan            r_scan;
    t_scan            n_scan;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_pf;
    logic [2:0]       w_set;
    logic             w_has;

    assign w_idx = CMP_W'(i_index);
    assign w_pos = CMP_W'(i_ctl.pos);
    assign w_pf  = CMP_W'(i_ctl.press_floor);
    assign w_has = |r_calls;

    always_comb begin
        case (i_ctl.press_button)
            BTN_UP:   w_set = 3'b001;
            BTN_DOWN: w_set = 3'b010;
            BTN_CAB:  w_set = 3'b100;
            default:  w_set = 3'b000;
        endcase
    end

    // press first, clear second
    always_comb begin
        n_calls = r_calls;
        if (i_ctl.load) begin
            if (i_ctl.press_valid && (w_pf == w_idx)) begin
                n_calls = n_calls | w_set;
            end
            if (i_ctl.clear_here && (w_pos == w_idx)) begin
                n_calls = 3'b000;
            end
        end
    end

    always_comb begin
        n_scan       = i_scan;
        n_scan.any   = i_scan.any | w_has;
        if (w_idx < w_pos) begin
            n_scan.below = i_scan.below | w_has;
        end else if (w_idx == w_pos) begin
            n_scan.here = r_calls;
        end else begin
            n_scan.above = i_scan.above | w_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calls      <= 3'b000;
            r_scan.valid <= 1'b0;
        end else begin
            r_calls      <= n_calls;
            r_scan.valid <= i_scan.valid;
        end
        r_scan.below <= n_scan.below;
        r_scan.here  <= n_scan.here;
        r_scan.above <= n_scan.above;
        r_scan.any   <= n_scan.any;
    end

    assign o_scan = r_scan;

endmodule

[tb/elevator_order_scheduler_test.sv]
`timescale 1ns / 100ps

module elevator_order_scheduler_test;
    import eos_pkg::*;

    localparam logic [1:0] BTN_NONE    = 2'd3;
    localparam int         IDLE_LIMIT  = 1000;
    localparam int         SETTLE      = 20;
    localparam int         PRINT_CAP   = 100;

    typedef struct packed {
        logic       press_valid;
        logic [1:0] press_floor;
        logic [1:0] press_button;
        logic       clear_here;
        logic [1:0] position_floor;
        logic       between_floors;
        logic [1:0] travel_dir;
    } t_car_event;

    // Mirror of the call table; computes the response each request must produce.
    class call_scoreboard;
        logic [2:0] calls [FLOORS];
        t_rsp       pending [$];
        int         errors;

        function new();
            foreach (calls[f]) calls[f] = '0;
            errors = 0;
        endfunction

        function bit calls_between(int lo, int hi);
            for (int f = lo; f < hi && f < FLOORS; f++)
                if (calls[f] != 3'b000) return 1'b1;
            return 1'b0;
        endfunction

        function void note_request(t_car_event ev);
            logic [1:0] dir;
            logic [2:0] here;
            bit         above;
            bit         below;
            bit         ahead;
            int         pos;
            t_rsp       exp_rsp;
            pos = int'(ev.position_floor);
            dir = (ev.travel_dir == DIR_UNKNOWN) ? DIR_STOP : ev.travel_dir;
            // press first, then clear
            if (ev.press_valid && ev.press_button <= BTN_CAB && int'(ev.press_floor) < FLOORS)
                calls[ev.press_floor][ev.press_button] = 1'b1;
            if (ev.clear_here && pos < FLOORS)
                calls[pos] = 3'b000;
            here = (pos < FLOORS) ? calls[pos] : 3'b000;
            exp_rsp.any_order   = calls_between(0, FLOORS);
            exp_rsp.floor_calls = here;
            exp_rsp.stop_here   = 1'b0;
            exp_rsp.next_dir    = DIR_STOP;
            if (ev.between_floors) begin
                if (calls_between(pos, FLOORS))
                    exp_rsp.next_dir = DIR_UP;
                else if (calls_between(0, pos))
                    exp_rsp.next_dir = DIR_DOWN;
            end else begin
                above = calls_between(pos + 1, FLOORS);
                below = calls_between(0, pos);
                ahead = (dir == DIR_UP) ? above : (dir == DIR_DOWN) ? below : 1'b0;
                if (here[BTN_CAB])
                    exp_rsp.stop_here = 1'b1;
                else if (here[BTN_DOWN] && dir == DIR_DOWN)
                    exp_rsp.stop_here = 1'b1;
                else if (here[BTN_UP] && dir == DIR_UP)
                    exp_rsp.stop_here = 1'b1;
                else if (!ahead && here != 3'b000)
                    exp_rsp.stop_here = 1'b1;
                if (dir == DIR_DOWN) begin
                    if (below) exp_rsp.next_dir = DIR_DOWN;
                    else if (above) exp_rsp.next_dir = DIR_UP;
                end else begin
                    if (above) exp_rsp.next_dir = DIR_UP;
                    else if (below) exp_rsp.next_dir = DIR_DOWN;
                end
            end
            pending.push_back(exp_rsp);
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp exp_rsp;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected response stop=%b dir=%0d any=%b calls=%b",
                                          got.stop_here, got.next_dir, got.any_order,
                                          got.floor_calls));
                return;
            end
            exp_rsp = pending.pop_front();
            if (got.stop_here !== exp_rsp.stop_here)
                report_mismatch($sformatf("stop_here %b, want %b",
                                          got.stop_here, exp_rsp.stop_here));
            if (got.next_dir !== exp_rsp.next_dir)
                report_mismatch($sformatf("next_dir %0d, want %0d",
                                          got.next_dir, exp_rsp.next_dir));
            if (got.any_order !== exp_rsp.any_order)
                report_mismatch($sformatf("any_order %b, want %b",
                                          got.any_order, exp_rsp.any_order));
            if (got.floor_calls !== exp_rsp.floor_calls)
                report_mismatch($sformatf("floor_calls %b, want %b",
                                          got.floor_calls, exp_rsp.floor_calls));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    eos_req_if req_bus ();
    eos_rsp_if rsp_bus ();

    elevator_order_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    call_scoreboard sb;
    int  req_seen;
    int  rsp_seen;
    int  idle_cycles;
    bit  burst;
    int  hold_len;

    // car walk used to build realistic request sequences
    int         car_pos;
    bit         car_btw;
    logic [1:0] car_dir;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                sb.note_request('{req_bus.press_valid, req_bus.press_floor,
                                  req_bus.press_button, req_bus.clear_here,
                                  req_bus.position_floor, req_bus.between_floors,
                                  req_bus.travel_dir});
                req_seen++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                sb.check_response('{rsp_bus.stop_here, rsp_bus.next_dir,
                                    rsp_bus.any_order, rsp_bus.floor_calls});
                rsp_seen++;
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // response side: random stalls, plus a long hold-off when requested
    initial begin : rsp_drain
        int n;
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_len > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len = 0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            n = rsp_seen;
            do @(negedge i_clk); while (rsp_seen == n);
        end
    end

    task automatic send_event(t_car_event ev);
        int gap;
        int n;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.press_valid    <= ev.press_valid;
        req_bus.press_floor    <= ev.press_floor;
        req_bus.press_button   <= ev.press_button;
        req_bus.clear_here     <= ev.clear_here;
        req_bus.position_floor <= ev.position_floor;
        req_bus.between_floors <= ev.between_floors;
        req_bus.travel_dir     <= ev.travel_dir;
        n = req_seen;
        do @(negedge i_clk); while (req_seen == n);
    endtask

    task automatic send_fields(logic pv, logic [1:0] pf, logic [1:0] pb, logic clr,
                               logic [1:0] pos, logic btw, logic [1:0] dir);
        send_event('{pv, pf, pb, clr, pos, btw, dir});
    endtask

    task automatic make_event(output t_car_event ev);
        if ($urandom_range(0, 9) == 0) begin
            // noise: any field value at all
            ev.press_valid    = 1'($urandom_range(0, 1));
            ev.press_floor    = 2'($urandom_range(0, 3));
            ev.press_button   = 2'($urandom_range(0, 3));
            ev.clear_here     = 1'($urandom_range(0, 1));
            ev.position_floor = 2'($urandom_range(0, 3));
            ev.between_floors = 1'($urandom_range(0, 1));
            ev.travel_dir     = 2'($urandom_range(0, 3));
            return;
        end
        if (car_btw) begin
            // arrive; going down the position moves to the floor below
            if (car_dir == DIR_DOWN) car_pos--;
            car_btw = 1'b0;
        end else if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 3) == 0)
                car_dir = 2'($urandom_range(0, 2));
            if (car_dir == DIR_UP && car_pos < FLOORS - 1) begin
                car_pos++;
                car_btw = 1'b1;
            end else if (car_dir == DIR_DOWN && car_pos > 0) begin
                car_btw = 1'b1;
            end else if (car_dir == DIR_UP) begin
                car_dir = DIR_DOWN;
            end else if (car_dir == DIR_DOWN) begin
                car_dir = DIR_UP;
            end
        end
        ev.press_valid    = 1'($urandom_range(0, 1));
        ev.press_floor    = 2'($urandom_range(0, FLOORS - 1));
        ev.press_button   = ($urandom_range(0, 15) == 0) ? BTN_NONE : 2'($urandom_range(0, 2));
        ev.clear_here     = !car_btw && ($urandom_range(0, 2) == 0);
        ev.position_floor = 2'(car_pos);
        ev.between_floors = car_btw;
        ev.travel_dir     = car_dir;
    endtask

    task automatic run_random(int count);
        t_car_event ev;
        repeat (count) begin
            make_event(ev);
            send_event(ev);
        end
    endtask

    initial begin
        sb          = new();
        req_seen    = 0;
        rsp_seen    = 0;
        idle_cycles = 0;
        burst       = 1'b0;
        hold_len    = 0;
        car_pos     = 0;
        car_btw     = 1'b0;
        car_dir     = DIR_STOP;

        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.press_valid    = 1'b0;
        req_bus.press_floor    = '0;
        req_bus.press_button   = '0;
        req_bus.clear_here     = 1'b0;
        req_bus.position_floor = '0;
        req_bus.between_floors = 1'b0;
        req_bus.travel_dir     = DIR_STOP;
        rsp_bus.ready          = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, button kinds, direction matching, special cases
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd0, 1'b0, DIR_STOP);
        send_fields(1'b1, 2'd3, BTN_CAB,  1'b0, 2'd0, 1'b0, DIR_STOP);
        send_fields(1'b1, 2'd0, BTN_UP,   1'b0, 2'd0, 1'b0, DIR_UP);
        send_fields(1'b1, 2'd0, BTN_DOWN, 1'b0, 2'd0, 1'b0, DIR_UP);
        send_fields(1'b1, 2'd1, BTN_DOWN, 1'b1, 2'd0, 1'b0, DIR_UP);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd1, 1'b0, DIR_UP);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd1, 1'b0, DIR_DOWN);
        // unknown button and unknown direction
        send_fields(1'b1, 2'd2, BTN_NONE, 1'b0, 2'd2, 1'b0, DIR_UNKNOWN);
        // between floors: position floor counts as above
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd3, 1'b1, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd0, 1'b1, DIR_UP);
        // press and clear at the same floor: clear wins
        send_fields(1'b1, 2'd3, BTN_CAB,  1'b1, 2'd3, 1'b0, DIR_UP);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd3, 1'b0, DIR_UP);
        send_fields(1'b1, 2'd2, BTN_UP,   1'b0, 2'd2, 1'b0, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b1, 2'd1, 1'b0, DIR_DOWN);
        // nothing ahead: any call here stops the car
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd2, 1'b0, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd2, 1'b0, DIR_UNKNOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b1, 2'd2, 1'b1, DIR_STOP);
        send_fields(1'b1, 2'd3, BTN_DOWN, 1'b0, 2'd0, 1'b1, DIR_UP);
        send_fields(1'b1, 2'd0, BTN_CAB,  1'b0, 2'd3, 1'b1, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd3, 1'b0, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b0, 2'd3, 1'b0, DIR_UP);
        send_fields(1'b1, 2'd1, BTN_UP,   1'b1, 2'd3, 1'b0, DIR_DOWN);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b1, 2'd0, 1'b0, DIR_UP);
        send_fields(1'b0, 2'd0, BTN_UP,   1'b1, 2'd1, 1'b0, DIR_STOP);

        run_random(350);

        burst = 1'b1;
        run_random(120);
        burst = 1'b0;

        // hold the response side off while requests keep coming
        hold_len = 150;
        run_random(40);

        // pause until the block has drained
        req_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);

        run_random(420);

        req_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending.size()));

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/eos_pkg.sv
rtl/eos_req_if.sv
rtl/eos_rsp_if.sv
rtl/eos_cell.sv
rtl/elevator_order_scheduler.sv
tb/elevator_order_scheduler_test.sv
